@@ hdl/isf_pkg.sv @@
// ----------------------------------------------------------------------------
// isf_pkg: shared types and constants of the image smooth/sharpen filter
// Configuration codes, filter modes, back end states and the weight lookup.
// ----------------------------------------------------------------------------
package isf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int PIX_W          = 8;
    localparam int PIX_MAX        = 255;
    localparam int HEIGHT_W       = 16;
    localparam int IMGW_REG_W     = 11;
    localparam int WEIGHT_W       = 10;
    localparam int WEIGHT_MAX     = 1023;
    localparam int WEIGHTS_W      = 60;
    localparam int AMOUNT_W       = 12;
    localparam int CFG_IDX_W      = 3;
    localparam int PROD_W         = 21;
    localparam int SHARP_W        = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_MODE    = 3'd0,
        CFG_KERNEL_RADIUS  = 3'd1,
        CFG_IMAGE_WIDTH    = 3'd2,
        CFG_IMAGE_HEIGHT   = 3'd3,
        CFG_GAUSS_WEIGHTS  = 3'd4,
        CFG_SHARPEN_AMOUNT = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_MEAN    = 2'd0,
        MODE_GAUSS   = 2'd1,
        MODE_SHARPEN = 2'd2
    } filter_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAPS,
        ST_DRAIN,
        ST_DIVIDE,
        ST_MULT,
        ST_FINISH
    } back_state_t;

    // effective settings seen by the back end
    typedef struct packed {
        logic [1:0]                 mode;
        logic [1:0]                 radius;
        logic [HEIGHT_W-1:0]        height;
        logic [WEIGHTS_W-1:0]       weights;
        logic signed [AMOUNT_W-1:0] amount;
    } isf_cfg_t;

    // weight for one squared-distance class, zero for classes without one
    function automatic logic [WEIGHT_W-1:0] isf_class_weight(
        input logic [4:0]           d2,
        input logic [WEIGHTS_W-1:0] w
    );
        logic [WEIGHT_W-1:0] r;
        case (d2)
            5'd0:    r = w[0  +: WEIGHT_W];
            5'd1:    r = w[10 +: WEIGHT_W];
            5'd2:    r = w[20 +: WEIGHT_W];
            5'd4:    r = w[30 +: WEIGHT_W];
            5'd5:    r = w[40 +: WEIGHT_W];
            5'd8:    r = w[50 +: WEIGHT_W];
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/isf_fifo.sv @@
// ----------------------------------------------------------------------------
// isf_fifo: short job queue between front and back end
// Register based first-in first-out store, depth from the package.
// ----------------------------------------------------------------------------
module isf_fifo
    import isf_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop && valid) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if ((push && !full) && !(pop && valid)) begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end else if (!(push && !full) && (pop && valid)) begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/isf_front.sv @@
// ----------------------------------------------------------------------------
// isf_front: input side, configuration and output scheduling
// Holds the settings, writes pixels into the ring store and decides which
// item releases an output; each released output becomes a queued job.
// ----------------------------------------------------------------------------
module isf_front
    import isf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    localparam int STORE_DEPTH = 2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS) + 2,
    localparam int ADDR_W      = $clog2(STORE_DEPTH),
    localparam int WID_W       = $clog2(MAX_WIDTH + 1),
    localparam int COL_W       = $clog2(MAX_WIDTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,     // [7:0] pixel_value
    input  logic                 s_tuser,     // [0] flush
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WEIGHTS_W-1:0] cfg_data,
    output isf_cfg_t             cfg,
    output logic [WID_W-1:0]     cfg_width,
    output logic                 wr_en,
    output logic [ADDR_W-1:0]    wr_addr,
    output logic [PIX_W-1:0]     wr_data,
    input  logic                 job_full,
    output logic                 job_push,
    output logic [ADDR_W-1:0]    job_center,
    output logic [HEIGHT_W-1:0]  job_row,
    output logic [COL_W-1:0]     job_col,
    output logic                 job_last
);

    logic [1:0]                 mode_reg;
    logic [1:0]                 radius_reg;
    logic [IMGW_REG_W-1:0]      width_reg;
    logic [HEIGHT_W-1:0]        height_reg;
    logic [WEIGHTS_W-1:0]       weights_reg;
    logic signed [AMOUNT_W-1:0] amount_reg;

    logic [ADDR_W-1:0]   wr_ptr_reg, pend_reg;
    logic [HEIGHT_W-1:0] orow_reg;
    logic [COL_W-1:0]    ocol_reg;

    logic [1:0]          eff_r;
    logic [WID_W-1:0]    eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic                accept, has_pix, emit, cfg_we;
    logic [ADDR_W-1:0]   pend_after, wr_after, need;
    logic [HEIGHT_W-1:0] rows_left;
    logic [WID_W-1:0]    cols_left;
    logic [1:0]          dr, dc;
    logic                col_wrap, row_wrap;

    assign eff_r = (32'(radius_reg) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_reg;
    assign eff_h = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = WID_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(width_reg);
        end
    end

    assign cfg.mode    = mode_reg;
    assign cfg.radius  = eff_r;
    assign cfg.height  = eff_h;
    assign cfg.weights = weights_reg;
    assign cfg.amount  = amount_reg;
    assign cfg_width   = eff_w;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign s_tready  = !job_full;
    assign accept    = s_tvalid && s_tready;
    assign has_pix   = !s_tuser;

    assign pend_after = pend_reg + ADDR_W'(has_pix);
    assign wr_after   = wr_ptr_reg + ADDR_W'(has_pix);

    // window reach below and to the right, clipped at the image border
    assign rows_left = (eff_h - HEIGHT_W'(1)) - orow_reg;
    assign cols_left = (eff_w - WID_W'(1)) - WID_W'(ocol_reg);
    assign dr = (HEIGHT_W'(eff_r) > rows_left) ? rows_left[1:0] : eff_r;
    assign dc = (WID_W'(eff_r) > cols_left) ? cols_left[1:0] : eff_r;
    assign need = ADDR_W'(dr) * ADDR_W'(eff_w) + ADDR_W'(dc) + ADDR_W'(1);
    assign emit = (pend_after >= need);

    assign col_wrap = (WID_W'(ocol_reg) + WID_W'(1) >= eff_w);
    assign row_wrap = ((HEIGHT_W+1)'(orow_reg) + (HEIGHT_W+1)'(1) >= (HEIGHT_W+1)'(eff_h));

    assign wr_en   = accept && has_pix;
    assign wr_addr = wr_ptr_reg;
    assign wr_data = s_tdata;

    assign job_push   = accept && emit;
    assign job_center = wr_after - pend_after;
    assign job_row    = orow_reg;
    assign job_col    = ocol_reg;
    assign job_last   = (orow_reg == eff_h - HEIGHT_W'(1)) &&
                        (WID_W'(ocol_reg) == eff_w - WID_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_MEAN;
            radius_reg  <= 2'd1;
            width_reg   <= IMGW_REG_W'(1024);
            height_reg  <= HEIGHT_W'(1024);
            weights_reg <= '0;
            amount_reg  <= AMOUNT_W'(256);
            wr_ptr_reg  <= '0;
            pend_reg    <= '0;
            orow_reg    <= '0;
            ocol_reg    <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_after;
                pend_reg   <= pend_after - ADDR_W'(emit);
                if (emit) begin
                    if (col_wrap) begin
                        ocol_reg <= '0;
                        orow_reg <= row_wrap ? '0 : orow_reg + HEIGHT_W'(1);
                    end else begin
                        ocol_reg <= ocol_reg + COL_W'(1);
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_FILTER_MODE: begin
                        mode_reg <= cfg_data[1:0];
                    end
                    CFG_KERNEL_RADIUS: begin
                        radius_reg <= cfg_data[1:0];
                        pend_reg   <= '0;
                        orow_reg   <= '0;
                        ocol_reg   <= '0;
                    end
                    CFG_IMAGE_WIDTH: begin
                        width_reg <= cfg_data[IMGW_REG_W-1:0];
                        pend_reg  <= '0;
                        orow_reg  <= '0;
                        ocol_reg  <= '0;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        height_reg <= cfg_data[HEIGHT_W-1:0];
                        pend_reg   <= '0;
                        orow_reg   <= '0;
                        ocol_reg   <= '0;
                    end
                    CFG_GAUSS_WEIGHTS: begin
                        weights_reg <= cfg_data;
                    end
                    CFG_SHARPEN_AMOUNT: begin
                        amount_reg <= $signed(cfg_data[AMOUNT_W-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ hdl/isf_back.sv @@
// ----------------------------------------------------------------------------
// isf_back: window filter engine
// Owns the pixel ring store, walks the window one tap a cycle, divides by
// the weight sum bit by bit, applies unsharp gain in sharpen mode and holds the result.
// ----------------------------------------------------------------------------
module isf_back
    import isf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    localparam int STORE_DEPTH = 2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS) + 2,
    localparam int ADDR_W      = $clog2(STORE_DEPTH),
    localparam int WID_W       = $clog2(MAX_WIDTH + 1),
    localparam int COL_W       = $clog2(MAX_WIDTH)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  isf_cfg_t            cfg,
    input  logic [WID_W-1:0]    cfg_width,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [PIX_W-1:0]    wr_data,
    input  logic                job_valid,
    output logic                job_pop,
    input  logic [ADDR_W-1:0]   job_center,
    input  logic [HEIGHT_W-1:0] job_row,
    input  logic [COL_W-1:0]    job_col,
    input  logic                job_last,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [PIX_W-1:0]    m_tdata,  // [7:0] result_pixel
    output logic                m_tlast
);

    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int TAPS_MAX  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int ACC_W     = $clog2(TAPS_MAX * WEIGHT_MAX * PIX_MAX + 1);
    localparam int WS_W      = $clog2(TAPS_MAX * WEIGHT_MAX + 1);
    localparam int CNT_W     = $clog2(ACC_W + 1);
    localparam int OFF_W     = ADDR_W + 1;
    localparam int YY_W      = HEIGHT_W + 2;
    localparam int XX_W      = WID_W + 2;

    logic [PIX_W-1:0] mem [MEM_DEPTH];

    back_state_t state_reg, state_next;

    logic signed [2:0]   dy_reg, dx_reg;
    logic [ADDR_W-1:0]   center_reg;
    logic [HEIGHT_W-1:0] row_reg;
    logic [COL_W-1:0]    col_reg;
    logic                last_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [WS_W-1:0]     wsum_reg, rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PIX_W-1:0]    orig_reg, blur_reg, rd_data_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [WEIGHT_W-1:0] tap_w_reg;
    logic                tap_in_reg, tap_ctr_reg, acc_en_reg;
    logic                out_valid_reg, out_last_reg;
    logic [PIX_W-1:0]    out_pix_reg;

    logic                issue, div_step, load_out, last_tap, gauss;
    logic signed [2:0]   r_s;
    logic [1:0]          dy_abs, dx_abs;
    logic [4:0]          d2;
    logic [WEIGHT_W-1:0] tap_w;
    logic signed [YY_W-1:0]  yy;
    logic signed [XX_W-1:0]  xx;
    logic                in_y, in_x;
    logic signed [OFF_W-1:0] off;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WS_W:0]       shifted;
    logic [WS_W+1:0]     sub;
    logic [PIX_W-1:0]    blur;
    logic signed [PIX_W:0]    diff;
    logic signed [SHARP_W-1:0] sharp;
    logic [PIX_W-1:0]    sharp_pix, res_pix;

    assign r_s   = $signed({1'b0, cfg.radius});
    assign gauss = (cfg.mode == MODE_GAUSS) || (cfg.mode == MODE_SHARPEN);

    // tap address, weight and border test
    assign dy_abs = dy_reg[2] ? 2'(-dy_reg) : dy_reg[1:0];
    assign dx_abs = dx_reg[2] ? 2'(-dx_reg) : dx_reg[1:0];
    assign d2     = 5'(dy_abs) * 5'(dy_abs) + 5'(dx_abs) * 5'(dx_abs);
    assign tap_w  = gauss ? isf_class_weight(d2, cfg.weights) : WEIGHT_W'(1);

    assign yy   = $signed({2'b00, row_reg}) + YY_W'(dy_reg);
    assign xx   = $signed({2'b00, WID_W'(col_reg)}) + XX_W'(dx_reg);
    assign in_y = !yy[YY_W-1] && (yy < $signed({2'b00, cfg.height}));
    assign in_x = !xx[XX_W-1] && (xx < $signed({2'b00, cfg_width}));

    assign off     = OFF_W'(dy_reg) * $signed(OFF_W'(cfg_width)) + OFF_W'(dx_reg);
    assign rd_addr = center_reg + off[ADDR_W-1:0];

    assign last_tap = (dx_reg == r_s) && (dy_reg == r_s);

    // one restoring division step
    assign shifted = {rem_reg, acc_reg[ACC_W-1]};
    assign sub     = {1'b0, shifted} - (WS_W+2)'(wsum_reg);

    always_comb begin
        if (wsum_reg == '0) begin
            blur = '0;
        end else if (acc_reg > ACC_W'(PIX_MAX)) begin
            blur = PIX_W'(PIX_MAX);
        end else begin
            blur = acc_reg[PIX_W-1:0];
        end
    end

    assign diff  = $signed({1'b0, orig_reg}) - $signed({1'b0, blur});
    assign sharp = $signed({{(SHARP_W-PIX_W-8){1'b0}}, orig_reg, 8'b0}) +
                   SHARP_W'(prod_reg);

    always_comb begin
        if (sharp[SHARP_W-1]) begin
            sharp_pix = '0;
        end else if (|sharp[SHARP_W-2:16]) begin
            sharp_pix = PIX_W'(PIX_MAX);
        end else begin
            sharp_pix = sharp[15:8];
        end
    end

    assign res_pix = (cfg.mode == MODE_SHARPEN) ? sharp_pix : blur_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) state_next = ST_TAPS;
            end
            ST_TAPS: begin
                if (last_tap) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (cnt_reg == CNT_W'(ACC_W - 1)) state_next = ST_MULT;
            end
            ST_MULT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        job_pop  = 1'b0;
        issue    = 1'b0;
        div_step = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:   job_pop  = job_valid;
            ST_TAPS:   issue    = 1'b1;
            ST_DIVIDE: div_step = 1'b1;
            ST_FINISH: load_out = !out_valid_reg || m_tready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            acc_en_reg <= issue;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ring store: one write port from the front, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            center_reg <= job_center;
            row_reg    <= job_row;
            col_reg    <= job_col;
            last_reg   <= job_last;
            dy_reg     <= -r_s;
            dx_reg     <= -r_s;
            wsum_reg   <= '0;
        end
        if (issue) begin
            tap_w_reg   <= tap_w;
            tap_in_reg  <= in_y && in_x;
            tap_ctr_reg <= (dy_reg == 3'sd0) && (dx_reg == 3'sd0);
            wsum_reg    <= wsum_reg + WS_W'(tap_w);
            if (dx_reg == r_s) begin
                dx_reg <= -r_s;
                dy_reg <= dy_reg + 3'sd1;
            end else begin
                dx_reg <= dx_reg + 3'sd1;
            end
        end
        if (job_pop) begin
            acc_reg <= '0;
        end else if (acc_en_reg) begin
            if (tap_in_reg) begin
                acc_reg <= acc_reg + ACC_W'(tap_w_reg) * ACC_W'(rd_data_reg);
            end
        end else if (div_step) begin
            if (!sub[WS_W+1]) begin
                rem_reg <= sub[WS_W-1:0];
                acc_reg <= {acc_reg[ACC_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[WS_W-1:0];
                acc_reg <= {acc_reg[ACC_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (acc_en_reg && tap_ctr_reg) begin
            orig_reg <= rd_data_reg;
        end
        if (state_reg == ST_DRAIN) begin
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (state_reg == ST_MULT) begin
            blur_reg <= blur;
            prod_reg <= PROD_W'(diff) * PROD_W'(cfg.amount);
        end
        if (load_out) begin
            out_pix_reg  <= res_pix;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

    // tap pipeline must be empty before the divider takes the sum
    a_drain_before_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |-> !acc_en_reg)
        else $error("tap read still in flight during divide");

    a_idle_no_taps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !acc_en_reg)
        else $error("tap accumulate while idle");

    a_out_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result shown without finishing a job");

endmodule

@@ hdl/image_smooth_sharpen_filter_top.sv @@
// ----------------------------------------------------------------------------
// image_smooth_sharpen_filter_top: streaming 2-D mean/gaussian/unsharp filter
// Raster-order 8-bit grayscale pixels in, filtered pixels out.
//
// s_ channel: one item per pixel; s_tuser set marks a flush item that carries
// no pixel and only lets pending outputs drain at the end of a frame.
// m_ channel: one filtered pixel per output; m_tlast flags the last pixel
// of a frame. cfg channel: register index and data, always ready; write
// only while the block is idle. Writing radius, width or height restarts
// the frame position; stored pixels are kept.
// The front accepts an item while the job queue has room and queues a job
// when the item releases an output (two job slots). The back walks the
// (2R+1)^2 window one tap per cycle from the ring store read port, then
// runs a bit-serial divider of 23 steps (default parameters). When the
// receiver stalls the finished result waits in the output register, the
// back finishes one more job and the front fills the queue, then s_tready
// drops. Reset clears positions and restores defaults; no clearing pass is
// needed, the store is used only where written.
// ----------------------------------------------------------------------------
module image_smooth_sharpen_filter_top
    import isf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,    // [7:0] pixel_value
    input  logic                 s_tuser,    // [0] flush
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,    // [7:0] result_pixel
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WEIGHTS_W-1:0] cfg_data
);

    localparam int STORE_DEPTH = 2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS) + 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int WID_W       = $clog2(MAX_WIDTH + 1);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int JOB_W       = ADDR_W + HEIGHT_W + COL_W + 1;

    isf_cfg_t            cfg;
    logic [WID_W-1:0]    cfg_width;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [PIX_W-1:0]    wr_data;
    logic                job_push, job_full, job_valid, job_pop;
    logic [ADDR_W-1:0]   f_center;
    logic [HEIGHT_W-1:0] f_row;
    logic [COL_W-1:0]    f_col;
    logic                f_last;
    logic [JOB_W-1:0]    q_data;

    isf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .cfg_width  (cfg_width),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .job_full   (job_full),
        .job_push   (job_push),
        .job_center (f_center),
        .job_row    (f_row),
        .job_col    (f_col),
        .job_last   (f_last)
    );

    isf_fifo #(
        .DATA_W (JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data ({f_center, f_row, f_col, f_last}),
        .full      (job_full),
        .pop       (job_pop),
        .valid     (job_valid),
        .pop_data  (q_data)
    );

    isf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cfg_width  (cfg_width),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .job_valid  (job_valid),
        .job_pop    (job_pop),
        .job_center (q_data[JOB_W-1 -: ADDR_W]),
        .job_row    (q_data[COL_W+1 +: HEIGHT_W]),
        .job_col    (q_data[1 +: COL_W]),
        .job_last   (q_data[0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
